### hw/rtl/dltq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dltq_pkg
// Shared types and defaults for the delta list timeout queue.
// ----------------------------------------------------------------------------
package dltq_pkg;

  localparam int DEF_MAX_ENTRIES = 16;
  localparam int DEF_DELAY_BITS  = 16;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_TICK   = 2'd1,
    OP_POP    = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HEAD,
    S_WALK,
    S_SHIFT_UP,
    S_PLACE,
    S_SHIFT_DOWN
  } state_t;

endpackage

### hw/rtl/delta_list_timeout_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delta_list_timeout_queue
// Timer queue kept as a delta list in one synchronous entry memory.
// ----------------------------------------------------------------------------
// Steps per word: tick, unused opcode and pop read the head entry; a pop then
//   moves the remaining entries toward the head one at a time. Insert walks the
//   list while the entry delays fit, then appends, or shifts the later entries up
//   one at a time and places the new entry; a full table refuses the insert.
// Throughput: one word at a time; the receiver cannot stall, done is high for one cycle.
// Reset clears occupancy and control; entry memory holds no reset value.
module delta_list_timeout_queue
  import dltq_pkg::*;
#(
  parameter int MAX_ENTRIES = dltq_pkg::DEF_MAX_ENTRIES,
  parameter int DELAY_BITS  = dltq_pkg::DEF_DELAY_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         opcode,
  input  logic [7:0]                         handle,
  input  logic [15:0]                        delay_ticks,
  output logic                               done,
  output logic                               expired_valid,
  output logic [7:0]                         expired_handle,
  output logic [1:0]                         status,
  output logic [$clog2(MAX_ENTRIES+1)-1:0]   entry_count
);

  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int EW = 8 + DELAY_BITS;
  localparam logic [CW-1:0] ONE  = CW'(1);
  localparam logic [CW-1:0] FULL = CW'(MAX_ENTRIES);

  state_t              state, state_next;
  opcode_t             op;
  logic [7:0]          hdl;
  logic [DELAY_BITS-1:0] rem, rem_next;
  logic [CW-1:0]       pos, pos_next;
  logic [CW-1:0]       k, k_next;
  logic [CW-1:0]       occ, occ_next;

  logic [EW-1:0]       mem [MAX_ENTRIES];
  logic [EW-1:0]       rdata;
  logic [CW-1:0]       ra, wa;
  logic                we;
  logic [EW-1:0]       wd;

  logic                done_next, ev_next;
  logic [7:0]          eh_next;
  status_t             st_next;

  logic [7:0]            rd_h;
  logic [DELAY_BITS-1:0] rd_d;
  logic [7:0]            pop_hdl;

  assign rd_h        = rdata[EW-1:DELAY_BITS];
  assign rd_d        = rdata[DELAY_BITS-1:0];
  assign busy        = (state != S_IDLE);
  assign entry_count = occ;

  // Entry memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa[AW-1:0]] <= wd;
    end
    rdata <= mem[ra[AW-1:0]];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      occ   <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      occ   <= occ_next;
      done  <= done_next;
    end
  end

  // Working and result registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      op  <= opcode_t'(opcode);
      hdl <= handle;
    end
    rem <= rem_next;
    pos <= pos_next;
    k   <= k_next;
    if (done_next) begin
      expired_valid  <= ev_next;
      expired_handle <= eh_next;
      status         <= st_next;
    end
  end

  // Sequencer: walk, shift and place entries
  always_comb begin
    state_next = state;
    rem_next   = rem;
    pos_next   = pos;
    k_next     = k;
    occ_next   = occ;
    ra         = '0;
    wa         = '0;
    we         = 1'b0;
    wd         = rdata;
    done_next  = 1'b0;
    ev_next    = 1'b0;
    eh_next    = '0;
    st_next    = STAT_OK;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          rem_next = DELAY_BITS'(delay_ticks);
          pos_next = '0;
          ra       = '0;
          state_next = (opcode_t'(opcode) == OP_INSERT) ? S_WALK : S_HEAD;
        end
      end
      S_HEAD: begin
        state_next = S_IDLE;
        done_next  = 1'b1;
        unique case (op)
          OP_TICK: begin
            if (occ != '0 && rd_d != '0) begin
              we = 1'b1;
              wa = '0;
              wd = {rd_h, rd_d - DELAY_BITS'(1)};
            end
          end
          OP_POP: begin
            if (occ != '0 && rd_d == '0) begin
              ev_next = 1'b1;
              eh_next = rd_h;
              if (occ > ONE) begin
                ra         = ONE;
                k_next     = ONE;
                state_next = S_SHIFT_DOWN;
                done_next  = 1'b0;
              end else begin
                occ_next = occ - ONE;
              end
            end else begin
              st_next = STAT_EMPTY;
            end
          end
          default: begin
          end
        endcase
      end
      S_WALK: begin
        priority if (occ == FULL) begin
          st_next    = STAT_FULL;
          done_next  = 1'b1;
          state_next = S_IDLE;
        end else if (pos < occ && rd_d <= rem) begin
          rem_next = rem - rd_d;
          pos_next = pos + ONE;
          ra       = pos + ONE;
        end else if (pos == occ) begin
          we         = 1'b1;
          wa         = pos;
          wd         = {hdl, rem};
          occ_next   = occ + ONE;
          done_next  = 1'b1;
          state_next = S_IDLE;
        end else begin
          k_next     = occ;
          ra         = occ - ONE;
          state_next = S_SHIFT_UP;
        end
      end
      S_SHIFT_UP: begin
        // rdata holds entry k-1; move it to k
        we = 1'b1;
        wa = k;
        if (k - ONE == pos) begin
          wd         = {rd_h, rd_d - rem};
          state_next = S_PLACE;
        end else begin
          k_next = k - ONE;
          ra     = k - CW'(2);
        end
      end
      S_PLACE: begin
        we         = 1'b1;
        wa         = pos;
        wd         = {hdl, rem};
        occ_next   = occ + ONE;
        done_next  = 1'b1;
        state_next = S_IDLE;
      end
      S_SHIFT_DOWN: begin
        // rdata holds entry k; move it to k-1
        we      = 1'b1;
        wa      = k - ONE;
        ev_next = 1'b1;
        eh_next = pop_hdl;
        if (k + ONE < occ) begin
          k_next = k + ONE;
          ra     = k + ONE;
        end else begin
          occ_next   = occ - ONE;
          done_next  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Hold the popped handle across the shift
  // (expired_handle is loaded at done only, so keep a copy while shifting)
  always_ff @(posedge clk) begin
    if (state == S_HEAD) begin
      pop_hdl <= rd_h;
    end
  end

  assert property (@(posedge clk) disable iff (rst) occ <= FULL)
    else $error("occupancy above table size");
  assert property (@(posedge clk) disable iff (rst) done |-> $past(busy))
    else $error("result without work in progress");
  assert property (@(posedge clk) disable iff (rst)
    (done && status == STAT_FULL) |-> occ == FULL)
    else $error("full status with room left");
  assert property (@(posedge clk) disable iff (rst)
    (done && expired_valid) |-> status == STAT_OK)
    else $error("pop result with bad status");

endmodule

### tb/sv/dltq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dltq_checker
// Watches the command and result channels of the delta list timeout queue,
// predicts each result from its own copy of the table, and counts mismatches.
// ----------------------------------------------------------------------------
module dltq_checker
  import dltq_pkg::*;
#(
  parameter int MAX_ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  opcode,
  input  logic [7:0]  handle,
  input  logic [15:0] delay_ticks,
  input  logic        done,
  input  logic        expired_valid,
  input  logic [7:0]  expired_handle,
  input  logic [1:0]  status,
  input  logic [$clog2(MAX_ENTRIES+1)-1:0] entry_count,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic       vld;
    logic [7:0] hnd;
    status_t    st;
    logic [4:0] cnt;
  } timeout_result_t;

  logic [7:0]  q_handles [MAX_ENTRIES];
  logic [15:0] q_deltas  [MAX_ENTRIES];
  int          q_count;
  timeout_result_t expected_q[$];

  // Apply one command to the shadow table and return its result.
  function automatic timeout_result_t apply_command(opcode_t op, logic [7:0] h,
                                                    logic [15:0] d);
    timeout_result_t r;
    int pos;
    logic [15:0] rem;
    r = '0;
    r.st = STAT_OK;
    case (op)
      OP_INSERT: begin
        if (q_count >= MAX_ENTRIES) begin
          r.st = STAT_FULL;
        end else begin
          pos = 0;
          rem = d;
          while (pos < q_count && q_deltas[pos] <= rem) begin
            rem = rem - q_deltas[pos];
            pos++;
          end
          if (pos < q_count) q_deltas[pos] = q_deltas[pos] - rem;
          for (int k = q_count; k > pos; k--) begin
            q_handles[k] = q_handles[k-1];
            q_deltas[k]  = q_deltas[k-1];
          end
          q_handles[pos] = h;
          q_deltas[pos]  = rem;
          q_count++;
        end
      end
      OP_TICK: begin
        if (q_count > 0 && q_deltas[0] != 0) q_deltas[0] = q_deltas[0] - 1;
      end
      OP_POP: begin
        if (q_count > 0 && q_deltas[0] == 0) begin
          r.vld = 1'b1;
          r.hnd = q_handles[0];
          for (int k = 1; k < q_count; k++) begin
            q_handles[k-1] = q_handles[k];
            q_deltas[k-1]  = q_deltas[k];
          end
          q_count--;
        end else begin
          r.st = STAT_EMPTY;
        end
      end
      default: ;
    endcase
    r.cnt = q_count[4:0];
    return r;
  endfunction

  assign pending = expected_q.size();

  // Predict on each accepted word, compare on each result strobe.
  always @(posedge clk) begin
    timeout_result_t exp_r;
    timeout_result_t got;
    if (rst) begin
      q_count <= 0;
      fail_count <= 0;
      expected_q.delete();
    end else begin
      if (start && !busy) expected_q.push_back(apply_command(opcode_t'(opcode), handle,
                                                             delay_ticks));
      if (done) begin
        got.vld = expired_valid;
        got.hnd = expired_handle;
        got.st  = status_t'(status);
        got.cnt = 5'(entry_count);
        if (expected_q.size() == 0) begin
          if (fail_count < 10) $display("ERROR: unexpected result %p", got);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = expected_q.pop_front();
          if (got !== exp_r) begin
            if (fail_count < 10) $display("ERROR: expected %p got %p", exp_r, got);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives insert, tick and pop commands into the delta list timeout queue
// with random gaps and gives the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module testbench;
  import dltq_pkg::*;

  localparam int MAXE = 16;
  localparam int WATCHDOG = 20000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [1:0]  opcode = OP_NONE;
  logic [7:0]  handle = '0;
  logic [15:0] delay_ticks = '0;
  logic        busy, done, expired_valid;
  logic [7:0]  expired_handle;
  logic [1:0]  status;
  logic [4:0]  entry_count;
  int          fail_count, pending;
  int          idle_cycles = 0;
  int          held;

  always #6 clk = ~clk;

  delta_list_timeout_queue dut (
    .clk, .rst, .start, .busy, .opcode, .handle, .delay_ticks, .done,
    .expired_valid, .expired_handle, .status, .entry_count
  );

  dltq_checker #(.MAX_ENTRIES(MAXE)) chk (
    .clk, .rst, .start, .busy, .opcode, .handle, .delay_ticks, .done,
    .expired_valid, .expired_handle, .status, .entry_count, .fail_count, .pending
  );

  // Watchdog on cycles with no word accepted and no result.
  always @(posedge clk) begin
    if ((start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Present one command word and hold it until accepted; maybe idle after.
  task automatic send_word(opcode_t op, logic [7:0] h, logic [15:0] d, bit gaps);
    opcode      <= op;
    handle      <= h;
    delay_ticks <= d;
    start       <= 1'b1;
    do @(posedge clk); while (busy);
    if (op == OP_INSERT && held < MAXE) held++;
    if (op == OP_POP && held > 0) held--;
    if (gaps && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // Random word: inserts with mostly short delays, ticks, pops, rarely an unused opcode.
  task automatic random_word(bit gaps);
    int sel;
    logic [15:0] d;
    sel = $urandom_range(0, 99);
    case ($urandom_range(0, 3))
      0: d = 16'($urandom_range(0, 3));
      1: d = 16'($urandom_range(0, 20));
      2: d = 16'($urandom);
      default: d = 16'($urandom_range(0, 8));
    endcase
    if (sel < 35) send_word(OP_INSERT, 8'($urandom), d, gaps);
    else if (sel < 65) send_word(OP_TICK, 8'($urandom), 16'($urandom), gaps);
    else if (sel < 97) send_word(OP_POP, 8'($urandom), 16'($urandom), gaps);
    else send_word(OP_NONE, 8'($urandom), 16'($urandom), gaps);
  endtask

  initial begin
    held = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // Directed: empty cases, extremes, equal expiry, full table.
    send_word(OP_TICK, 8'h00, 16'h0000, 1'b0);
    send_word(OP_POP, 8'hff, 16'hffff, 1'b0);
    send_word(OP_NONE, 8'hff, 16'hffff, 1'b0);
    send_word(OP_INSERT, 8'hff, 16'hffff, 1'b0);
    send_word(OP_INSERT, 8'h00, 16'h0000, 1'b0);
    send_word(OP_INSERT, 8'h55, 16'h0002, 1'b0);
    send_word(OP_INSERT, 8'haa, 16'h0002, 1'b0);
    send_word(OP_INSERT, 8'h11, 16'h0001, 1'b0);
    for (int i = 0; i < 11; i++) send_word(OP_INSERT, 8'(i), 16'(i * 3), 1'b0);
    send_word(OP_INSERT, 8'h77, 16'h0005, 1'b0);
    send_word(OP_POP, 8'h00, 16'h0000, 1'b0);
    send_word(OP_POP, 8'h00, 16'h0000, 1'b0);
    send_word(OP_TICK, 8'h00, 16'h0000, 1'b0);
    send_word(OP_POP, 8'h00, 16'h0000, 1'b0);
    // Random body with gaps, then a final stretch without gaps.
    for (int i = 0; i < 1250; i++) random_word(1'b1);
    for (int i = 0; i < 150; i++) random_word(1'b0);
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

### sim.f
hw/rtl/dltq_pkg.sv
hw/rtl/delta_list_timeout_queue.sv
tb/sv/dltq_checker.sv
tb/sv/testbench.sv
